// ----- src/ntv_pkg.sv -----
// ----------------------------------------------------------------------------
// ntv_pkg
// Shared types, character codes and the character classifier used by the
// numeric text validator.
// ----------------------------------------------------------------------------
package ntv_pkg;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EXP_UP = 8'h45;
  localparam logic [7:0] CH_EXP_LO = 8'h65;

  typedef enum logic [1:0] {
    IP_LEAD,
    IP_BODY,
    IP_TRAIL,
    IP_FAIL
  } int_phase_t;

  typedef enum logic [3:0] {
    NP_LEAD,
    NP_SIGN,
    NP_INT,
    NP_DOTN,
    NP_FRAC,
    NP_EXP0,
    NP_EXPB,
    NP_TRAIL,
    NP_FAIL
  } num_phase_t;

  typedef struct packed {
    logic blank;
    logic digit;
    logic sign;
    logic dot;
    logic expo;
  } char_class_t;

  typedef struct packed {
    logic is_integer;
    logic is_number;
  } verdict_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r.blank = c inside {CH_SPACE, CH_TAB};
    r.digit = c inside {[CH_ZERO:CH_NINE]};
    r.sign  = c inside {CH_PLUS, CH_MINUS};
    r.dot   = (c == CH_DOT);
    r.expo  = c inside {CH_EXP_LO, CH_EXP_UP};
    return r;
  endfunction

endpackage

// ----- src/numeric_text_validator_top.sv -----
// ----------------------------------------------------------------------------
// numeric_text_validator_top
// Checks a text field, one character per request, for integer and number form.
// ----------------------------------------------------------------------------
// Path: a field's last character, once accepted, waits in the input register;
//   when it moves on, the field's verdict is loaded into the result register
//   and held there until it is taken.
// Throughput: one character per cycle; the input stalls only when a last
//   character is held while the result register is still occupied and stalled.
// Reset (rst, synchronous, active high) empties both registers and returns
//   both recognisers to the leading blank phase.
module numeric_text_validator_top
  import ntv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_integer,
  output logic       is_number
);

  // Input register: the accepted character waits here until it moves on.
  logic       hold_vld;
  logic       hold_vld_next;
  logic [7:0] hold_ch;
  logic       hold_last;

  logic       in_take;
  logic       adv;
  logic       load_out;
  logic       out_vld_next;
  verdict_t   verdict;

  // A character that ends no field never needs the result register, so it
  // always moves on. A last character moves on once the result register is
  // empty or is being emptied in the same cycle.
  assign adv      = hold_vld && (!hold_last || !out_valid || !out_stall);
  assign load_out = adv && hold_last;

  // The input register is free when it is empty or its content moves on now.
  assign in_stall = hold_vld && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_vld_next = hold_vld;
    if (in_take) begin
      hold_vld_next = 1'b1;
    end else if (adv) begin
      hold_vld_next = 1'b0;
    end

    out_vld_next = out_valid;
    if (load_out) begin
      out_vld_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_vld_next = 1'b0;
    end
  end

  ntv_dfa u_dfa (
    .clk     (clk),
    .rst     (rst),
    .step    (adv),
    .ch      (hold_ch),
    .last    (hold_last),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      hold_vld  <= hold_vld_next;
      out_valid <= out_vld_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_ch   <= ch;
      hold_last <= last;
    end
    if (load_out) begin
      is_integer <= verdict.is_integer;
      is_number  <= verdict.is_number;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_vld)
    else $error("input stalled with an empty input register");

  a_blocked_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (hold_vld && hold_last && out_valid && out_stall) |-> in_stall)
    else $error("last character advanced over an unread result");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result lost after field end");

  a_taken_result_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !load_out) |=> !out_valid)
    else $error("result repeated after being taken");
`endif

endmodule

// ----- src/ntv_dfa.sv -----
// ----------------------------------------------------------------------------
// ntv_dfa
// The two recognisers, integer form and number form, with their phase
// registers. Gives the verdict for the field on the step of its last request.
// ----------------------------------------------------------------------------
module ntv_dfa
  import ntv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       last,
  output verdict_t   verdict
);

  int_phase_t  int_phase;
  int_phase_t  int_phase_adv;
  int_phase_t  int_phase_next;
  num_phase_t  num_phase;
  num_phase_t  num_phase_adv;
  num_phase_t  num_phase_next;
  char_class_t cls;

  always_comb begin
    cls = classify(ch);

    case (int_phase)
      IP_LEAD: begin
        if (cls.blank)                  int_phase_adv = IP_LEAD;
        else if (cls.sign || cls.digit) int_phase_adv = IP_BODY;
        else                            int_phase_adv = IP_FAIL;
      end
      IP_BODY: begin
        if (cls.digit)      int_phase_adv = IP_BODY;
        else if (cls.blank) int_phase_adv = IP_TRAIL;
        else                int_phase_adv = IP_FAIL;
      end
      IP_TRAIL: begin
        int_phase_adv = cls.blank ? IP_TRAIL : IP_FAIL;
      end
      default: begin
        int_phase_adv = IP_FAIL;
      end
    endcase

    case (num_phase)
      NP_LEAD: begin
        if (cls.blank)      num_phase_adv = NP_LEAD;
        else if (cls.sign)  num_phase_adv = NP_SIGN;
        else if (cls.digit) num_phase_adv = NP_INT;
        else if (cls.dot)   num_phase_adv = NP_DOTN;
        else if (cls.expo)  num_phase_adv = NP_EXP0;
        else                num_phase_adv = NP_FAIL;
      end
      NP_SIGN: begin
        if (cls.digit)      num_phase_adv = NP_INT;
        else if (cls.dot)   num_phase_adv = NP_DOTN;
        else if (cls.expo)  num_phase_adv = NP_EXP0;
        else if (cls.blank) num_phase_adv = NP_TRAIL;
        else                num_phase_adv = NP_FAIL;
      end
      NP_INT: begin
        if (cls.digit)      num_phase_adv = NP_INT;
        else if (cls.dot)   num_phase_adv = NP_FRAC;
        else if (cls.expo)  num_phase_adv = NP_EXP0;
        else if (cls.blank) num_phase_adv = NP_TRAIL;
        else                num_phase_adv = NP_FAIL;
      end
      NP_DOTN: begin
        num_phase_adv = cls.digit ? NP_FRAC : NP_FAIL;
      end
      NP_FRAC: begin
        if (cls.digit)      num_phase_adv = NP_FRAC;
        else if (cls.expo)  num_phase_adv = NP_EXP0;
        else if (cls.blank) num_phase_adv = NP_TRAIL;
        else                num_phase_adv = NP_FAIL;
      end
      NP_EXP0: begin
        if (cls.sign || cls.digit) num_phase_adv = NP_EXPB;
        else if (cls.blank)        num_phase_adv = NP_TRAIL;
        else                       num_phase_adv = NP_FAIL;
      end
      NP_EXPB: begin
        if (cls.digit)      num_phase_adv = NP_EXPB;
        else if (cls.blank) num_phase_adv = NP_TRAIL;
        else                num_phase_adv = NP_FAIL;
      end
      NP_TRAIL: begin
        num_phase_adv = cls.blank ? NP_TRAIL : NP_FAIL;
      end
      default: begin
        num_phase_adv = NP_FAIL;
      end
    endcase

    verdict.is_integer = (int_phase_adv == IP_BODY) || (int_phase_adv == IP_TRAIL);
    verdict.is_number  = (num_phase_adv == NP_SIGN) || (num_phase_adv == NP_INT)  ||
                         (num_phase_adv == NP_FRAC) || (num_phase_adv == NP_EXPB) ||
                         (num_phase_adv == NP_TRAIL);

    // Both recognisers start afresh once a field has ended.
    int_phase_next = int_phase;
    num_phase_next = num_phase;
    if (step) begin
      int_phase_next = last ? IP_LEAD : int_phase_adv;
      num_phase_next = last ? NP_LEAD : num_phase_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_phase <= IP_LEAD;
      num_phase <= NP_LEAD;
    end else begin
      int_phase <= int_phase_next;
      num_phase <= num_phase_next;
    end
  end

endmodule

// ----- dv/ntv_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// ntv_tb_pkg
// Verdict scoreboard for the numeric text validator. It tracks the integer
// and number recognisers for each accepted character and holds the verdicts
// still owed by the block.
// ----------------------------------------------------------------------------
package ntv_tb_pkg;

  import ntv_pkg::*;

  typedef logic [7:0] field_t[$];

  class literal_board;
    int_phase_t int_ph;
    num_phase_t num_ph;
    verdict_t   pending_verdicts[$];
    int         errors;

    function new();
      int_ph = IP_LEAD;
      num_ph = NP_LEAD;
      errors = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_sign(logic [7:0] c);
      return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function bit is_expo(logic [7:0] c);
      return c == CH_EXP_LO || c == CH_EXP_UP;
    endfunction

    function int_phase_t next_int(int_phase_t p, logic [7:0] c);
      case (p)
        IP_LEAD: begin
          if (is_blank(c)) return IP_LEAD;
          if (is_sign(c) || is_digit(c)) return IP_BODY;
        end
        IP_BODY: begin
          if (is_digit(c)) return IP_BODY;
          if (is_blank(c)) return IP_TRAIL;
        end
        IP_TRAIL: begin
          if (is_blank(c)) return IP_TRAIL;
        end
        default: ;
      endcase
      return IP_FAIL;
    endfunction

    function num_phase_t next_num(num_phase_t p, logic [7:0] c);
      case (p)
        NP_LEAD: begin
          if (is_blank(c)) return NP_LEAD;
          if (is_sign(c)) return NP_SIGN;
          if (is_digit(c)) return NP_INT;
          if (c == CH_DOT) return NP_DOTN;
          if (is_expo(c)) return NP_EXP0;
        end
        NP_SIGN: begin
          if (is_digit(c)) return NP_INT;
          if (c == CH_DOT) return NP_DOTN;
          if (is_expo(c)) return NP_EXP0;
          if (is_blank(c)) return NP_TRAIL;
        end
        NP_INT: begin
          if (is_digit(c)) return NP_INT;
          if (c == CH_DOT) return NP_FRAC;
          if (is_expo(c)) return NP_EXP0;
          if (is_blank(c)) return NP_TRAIL;
        end
        NP_DOTN: begin
          if (is_digit(c)) return NP_FRAC;
        end
        NP_FRAC: begin
          if (is_digit(c)) return NP_FRAC;
          if (is_expo(c)) return NP_EXP0;
          if (is_blank(c)) return NP_TRAIL;
        end
        NP_EXP0: begin
          if (is_sign(c) || is_digit(c)) return NP_EXPB;
          if (is_blank(c)) return NP_TRAIL;
        end
        NP_EXPB: begin
          if (is_digit(c)) return NP_EXPB;
          if (is_blank(c)) return NP_TRAIL;
        end
        NP_TRAIL: begin
          if (is_blank(c)) return NP_TRAIL;
        end
        default: ;
      endcase
      return NP_FAIL;
    endfunction

    // Advances both recognisers; the last character of a field owes a verdict.
    function void note_char(logic [7:0] c, logic fin);
      verdict_t v;
      int_ph = next_int(int_ph, c);
      num_ph = next_num(num_ph, c);
      if (fin) begin
        v.is_integer = (int_ph == IP_BODY) || (int_ph == IP_TRAIL);
        v.is_number  = (num_ph == NP_SIGN) || (num_ph == NP_INT) ||
                       (num_ph == NP_FRAC) || (num_ph == NP_EXPB) ||
                       (num_ph == NP_TRAIL);
        pending_verdicts = {pending_verdicts, v};
        int_ph = IP_LEAD;
        num_ph = NP_LEAD;
      end
    endfunction

    function void check_verdict(logic got_int, logic got_num);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("verdict with no field pending: is_integer=%0b is_number=%0b",
               got_int, got_num);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (got_int !== v.is_integer) begin
        $error("is_integer: expected %0b, got %0b", v.is_integer, got_int);
        errors++;
      end
      if (got_num !== v.is_number) begin
        $error("is_number: expected %0b, got %0b", v.is_number, got_num);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction

    function void close_out();
      if (pending_verdicts.size() != 0) begin
        $error("%0d verdicts never arrived", pending_verdicts.size());
        errors++;
      end
    endfunction
  endclass

endpackage

// ----- dv/numeric_text_validator_top_tb.sv -----
// ----------------------------------------------------------------------------
// numeric_text_validator_top_tb
// Sends text fields one character per request into the validator and checks
// every verdict against a scoreboard that tracks both recognisers. A directed
// run of the odd corners of the number syntax is followed by random fields,
// with bursty input, patterned output stalls and pauses that drain the block.
// ----------------------------------------------------------------------------
module numeric_text_validator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ntv_pkg::*;
  import ntv_tb_pkg::*;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
  typedef enum {FK_NUMBER, FK_INTEGER, FK_MUTATED, FK_NOISE} field_kind_t;

  localparam int RANDOM_CHARS = 1300;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] ch        = CH_SPACE;
  logic       last      = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_integer;
  logic       is_number;

  literal_board board;
  int          burst_left = 0;
  int          chars_sent = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_tick = 0;

  numeric_text_validator_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ch         (ch),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_integer (is_integer),
    .is_number  (is_number)
  );

  always #4 clk = ~clk;

  // Every request is observed at the rising edge, when the inputs driven at
  // the falling edge are settled. A verdict always belongs to a field whose
  // last character was taken at an earlier edge, so the order of the two
  // calls within one edge does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_verdict(is_integer, is_number);
      if (in_valid && !in_stall) board.note_char(ch, last);
    end
  end

  // The receiver changes its stall behaviour at random intervals: no stall
  // at all, occasional single stalls, long stretches of stall, or a fixed
  // rhythm that lines up with different phases of the sender's bursts.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 150);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  // Offers one character and returns once the block has taken it. The sender
  // works in bursts; a burst that runs out is followed by a random gap, and
  // now and then by none, so valid may stay high across many requests.
  task automatic put_char(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    ch       = c;
    last     = fin;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_field(input field_t f);
    foreach (f[i]) put_char(f[i], i == f.size() - 1);
  endtask

  // Holds the sender back until every verdict owed has been delivered.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic field_t text_field(input string s);
    field_t f;
    for (int i = 0; i < s.len(); i++) f = {f, s[i]};
    return f;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  function automatic logic [7:0] pick_expo();
    return $urandom_range(0, 1) ? CH_EXP_LO : CH_EXP_UP;
  endfunction

  // Half the time one of the characters the recognisers care about, otherwise
  // any legal byte at all.
  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 9))
      0:       return pick_blank();
      1:       return pick_sign();
      2:       return CH_DOT;
      3:       return pick_expo();
      4:       return pick_digit();
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // A field shaped like a number, each part present or absent at random, so
  // that every phase of the number recogniser is reached with varied content.
  function automatic field_t make_number();
    field_t f;
    repeat ($urandom_range(0, 2)) f = {f, pick_blank()};
    if ($urandom_range(0, 2) == 0) f = {f, pick_sign()};
    repeat ($urandom_range(0, 4)) f = {f, pick_digit()};
    if ($urandom_range(0, 2) == 0) begin
      f = {f, CH_DOT};
      repeat ($urandom_range(0, 3)) f = {f, pick_digit()};
    end
    if ($urandom_range(0, 2) == 0) begin
      f = {f, pick_expo()};
      if ($urandom_range(0, 1)) f = {f, pick_sign()};
      repeat ($urandom_range(0, 3)) f = {f, pick_digit()};
    end
    repeat ($urandom_range(0, 2)) f = {f, pick_blank()};
    if (f.size() == 0) f = {f, pick_digit()};
    return f;
  endfunction

  function automatic field_t make_integer();
    field_t f;
    repeat ($urandom_range(0, 2)) f = {f, pick_blank()};
    if ($urandom_range(0, 1)) f = {f, pick_sign()};
    repeat ($urandom_range(0, 5)) f = {f, pick_digit()};
    repeat ($urandom_range(0, 2)) f = {f, pick_blank()};
    if (f.size() == 0) f = {f, pick_digit()};
    return f;
  endfunction

  function automatic field_t make_field();
    field_t f;
    int k;
    int r;
    field_kind_t kind;
    r = $urandom_range(0, 99);
    kind = (r < 45) ? FK_NUMBER : (r < 65) ? FK_INTEGER : (r < 85) ? FK_MUTATED : FK_NOISE;
    case (kind)
      FK_NUMBER:  f = make_number();
      FK_INTEGER: f = make_integer();
      FK_MUTATED: begin
        // A number-shaped field altered by one replaced, inserted or lost character.
        f = make_number();
        k = $urandom_range(0, f.size() - 1);
        case ($urandom_range(0, 2))
          0:       f[k] = pick_noise();
          1:       f.insert(k, pick_noise());
          default: if (f.size() > 1) f.delete(k); else f[k] = pick_noise();
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 6)) f = {f, pick_noise()};
      end
    endcase
    return f;
  endfunction

  initial begin
    field_t f;
    int     fields;
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: a lone sign with and without blanks, a trailing dot,
    // exponents with nothing before them or a sign or blank after them, a
    // final bare exponent, a blank-only field, a leading dot with and without
    // a digit, an integer with a trailing tab, and the extreme byte values.
    send_field(text_field("+"));
    send_field(text_field(" - "));
    send_field(text_field("1."));
    send_field(text_field("e5"));
    send_field(text_field("1e+"));
    send_field(text_field("e "));
    send_field(text_field("E"));
    send_field(text_field("\t"));
    send_field(text_field(".5"));
    send_field(text_field("."));
    send_field(text_field("09\t"));
    f = {};
    f = {f, 8'h01};
    f = {f, 8'hFF};
    send_field(f);

    // Let the block empty completely before the random part starts.
    drain();

    chars_sent = 0;
    fields = 0;
    while (chars_sent < RANDOM_CHARS) begin
      send_field(make_field());
      fields++;
      if (fields % 60 == 0) drain();
    end

    drain();
    repeat (4) @(posedge clk);
    board.close_out();
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // This watchdog allows far more time than a correct run needs.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
src/ntv_pkg.sv
src/ntv_dfa.sv
src/numeric_text_validator_top.sv
dv/ntv_tb_pkg.sv
dv/numeric_text_validator_top_tb.sv
